// ===== sv/gaad_pkg.sv =====
// Shared types and constants for the gated A-scan amplitude detector.
// No dependencies; compile first.
package gaad_pkg;

  localparam logic [12:0] MAX_LINE_POINTS = 13'd4096;
  localparam logic [7:0]  ARM_LOW         = 8'h7F;

  typedef enum logic [2:0] {
    REG_GATE_START   = 3'd0,
    REG_GATE_STOP    = 3'd1,
    REG_AMP_MODE     = 3'd2,
    REG_GATE_SIGNED  = 3'd3,
    REG_DATA_SIGNED  = 3'd4,
    REG_LINE_LENGTH  = 3'd5,
    REG_ENCODER_MODE = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AMP_ABS = 2'd0,
    AMP_MAX = 2'd1,
    AMP_MIN = 2'd2,
    AMP_P2P = 2'd3
  } amp_mode_t;

  typedef struct packed {
    logic [11:0] gate_start;
    logic [12:0] gate_stop;
    amp_mode_t   amp_mode;
    logic        gate_signed;
    logic        data_signed;
    logic [12:0] line_length;
    logic        encoder_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         sample;
    logic [11:0]        sample_pos;
    logic               shot_end;
    logic [31:0]        shot_sequence;
    logic signed [15:0] encoder_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  amplitude;
    logic [11:0] line_index;
    logic        line_restart;
  } out_item_t;

  typedef struct packed {
    logic        produce;
    logic [11:0] index;
    logic        restart;
  } line_res_t;

endpackage

// ===== sv/gaad_in_if.sv =====
// Sample channel: valid/ready handshake carrying one A-scan sample transaction.
// Depends on gaad_pkg.
interface gaad_in_if import gaad_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gaad_out_if.sv =====
// Result channel: valid/ready handshake carrying one amplitude transaction.
// Depends on gaad_pkg.
interface gaad_out_if import gaad_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gaad_peak.sv =====
// Gate window check, signed/unsigned peak trackers and amplitude selection.
// Depends on gaad_pkg.
module gaad_peak import gaad_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] sample,
  input  logic [11:0] sample_pos,
  input  logic       shot_end,
  output logic [7:0] amplitude
);

  logic signed [7:0] hi_r, lo_r;
  logic [7:0]        up_r;
  logic signed [7:0] hi_nxt, lo_nxt;
  logic [7:0]        up_nxt;
  logic              in_gate;
  logic signed [7:0] s;
  logic signed [8:0] hi9, lo9, neg_lo, v;

  assign in_gate = (sample_pos >= cfg.gate_start) && ({1'b0, sample_pos} < cfg.gate_stop);
  assign s       = $signed(sample);

  always_comb begin
    hi_nxt = (in_gate && (s > hi_r)) ? s : hi_r;
    lo_nxt = (in_gate && (s < lo_r)) ? s : lo_r;
    up_nxt = (in_gate && (sample > up_r)) ? sample : up_r;
  end

  // Amplitude is taken from the peaks including the current sample.
  assign hi9    = {hi_nxt[7], hi_nxt};
  assign lo9    = {lo_nxt[7], lo_nxt};
  assign neg_lo = -lo9;

  always_comb begin
    case (cfg.amp_mode)
      AMP_ABS: v = (lo_nxt[7] && (hi9 < neg_lo)) ? neg_lo : hi9;
      AMP_MAX: v = hi9;
      AMP_MIN: v = lo9;
      AMP_P2P: v = hi9 - lo9;
      default: v = hi9;
    endcase
    if (!cfg.data_signed) begin
      amplitude = cfg.gate_signed ? {1'b0, up_nxt[7:1]} : up_nxt;
    end else begin
      amplitude = cfg.gate_signed ? v[7:0] : {v[6:0], 1'b0};
    end
  end

  // Rearm after every end-of-shot sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= ARM_LOW;
      up_r <= '0;
    end else if (step) begin
      if (shot_end) begin
        hi_r <= '0;
        lo_r <= ARM_LOW;
        up_r <= '0;
      end else begin
        hi_r <= hi_nxt;
        lo_r <= lo_nxt;
        up_r <= up_nxt;
      end
    end
  end

  a_hi_nonneg: assert property (@(posedge clk) disable iff (!rst_n) !hi_r[7])
    else $error("signed peak high went negative");

endmodule

// ===== sv/gaad_line.sv =====
// C-scan line index: sequence base tracking with wrap, or encoder range check.
// Depends on gaad_pkg.
module gaad_line import gaad_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               step_last,
  input  logic [31:0]        shot_sequence,
  input  logic signed [15:0] encoder_index,
  output line_res_t          res
);

  logic [31:0] base_r, base_nxt;
  logic        captured_r;
  logic [12:0] len;
  logic [31:0] diff;
  logic        seq_over, enc_bad, len_ok;

  assign len    = (cfg.line_length > MAX_LINE_POINTS) ? MAX_LINE_POINTS : cfg.line_length;
  assign len_ok = (len != '0);
  // Before the first shot the base is the current sequence, so the offset is zero.
  assign diff     = shot_sequence - (captured_r ? base_r : shot_sequence);
  assign seq_over = (diff[31:13] != '0) || (diff[12:0] >= len);
  assign enc_bad  = encoder_index[15] || (encoder_index[14:0] >= {2'b00, len});

  always_comb begin
    res.produce = len_ok && (!cfg.encoder_mode || !enc_bad);
    res.restart = !cfg.encoder_mode && seq_over;
    if (cfg.encoder_mode) begin
      res.index = encoder_index[11:0];
    end else begin
      res.index = seq_over ? '0 : diff[11:0];
    end
    base_nxt = base_r;
    if (!captured_r || (len_ok && !cfg.encoder_mode && seq_over)) begin
      base_nxt = shot_sequence;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      captured_r <= 1'b0;
    end else if (step_last) begin
      base_r     <= base_nxt;
      captured_r <= 1'b1;
    end
  end

  a_base_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    captured_r |=> captured_r)
    else $error("sequence base capture flag dropped");

endmodule

// ===== sv/gated_ascan_amplitude_detector.sv =====
// Gated A-scan amplitude detector: one sample transaction per clock in while
// not stalled, one amplitude transaction out per shot. Samples are registered
// on acceptance and then resolved (gate compare, peak update, line index
// subtract and compare) into the output register once it can take a result,
// so the block sustains one sample per cycle while results are taken.
// in_ch.ready stays high while the output register is empty or being taken;
// it drops only when a result is stalled and a sample waits behind it.
// Samples inside [gate_start, gate_stop) update the peaks; on a shot_end sample
// the amplitude is formed from the peaks including that sample and the peaks
// are rearmed. A shot with a zero line length, or in encoder mode an encoder
// index outside the line, yields no result. Write configuration only while idle.
// Depends on gaad_pkg, gaad_in_if, gaad_out_if, gaad_peak and gaad_line.
module gated_ascan_amplitude_detector import gaad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  gaad_in_if.sink     in_ch,
  gaad_out_if.source  out_ch
);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      out_free, s1_adv, in_accept;
  logic [7:0] amplitude;
  line_res_t line_res;

  // Configuration registers: indexed write, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_start   <= '0;
      cfg_r.gate_stop    <= '0;
      cfg_r.amp_mode     <= AMP_MAX;
      cfg_r.gate_signed  <= 1'b0;
      cfg_r.data_signed  <= 1'b0;
      cfg_r.line_length  <= 13'd200;
      cfg_r.encoder_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GATE_START:   cfg_r.gate_start   <= cfg_data[11:0];
        REG_GATE_STOP:    cfg_r.gate_stop    <= cfg_data;
        REG_AMP_MODE:     cfg_r.amp_mode     <= amp_mode_t'(cfg_data[1:0]);
        REG_GATE_SIGNED:  cfg_r.gate_signed  <= cfg_data[0];
        REG_DATA_SIGNED:  cfg_r.data_signed  <= cfg_data[0];
        REG_LINE_LENGTH:  cfg_r.line_length  <= cfg_data;
        REG_ENCODER_MODE: cfg_r.encoder_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the output register can take a result.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_ch.data;
    end
  end

  gaad_peak u_peak (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step       (s1_adv),
    .sample     (s1_item_r.sample),
    .sample_pos (s1_item_r.sample_pos),
    .shot_end   (s1_item_r.shot_end),
    .amplitude  (amplitude)
  );

  gaad_line u_line (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .step_last     (s1_adv && s1_item_r.shot_end),
    .shot_sequence (s1_item_r.shot_sequence),
    .encoder_index (s1_item_r.encoder_index),
    .res           (line_res)
  );

  // Output register: load on a producing shot end, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_item_r.shot_end && line_res.produce;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r.amplitude    <= amplitude;
      out_item_r.line_index   <= line_res.index;
      out_item_r.line_restart <= line_res.restart;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  a_out_from_shot_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_item_r.shot_end))
    else $error("result raised without an end-of-shot sample");

  a_restart_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.line_restart) |-> (out_item_r.line_index == '0))
    else $error("line restart with nonzero line index");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled while a stage was free");

endmodule
